FILE: sv/assert_macros.svh
// Assertion macros shared by the Base64 stream encoder RTL.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B64E_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// Next-cycle implication, checked outside reset.
`define B64E_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

FILE: sv/b64e_pkg.sv
// Types, constants and the alphabet function of the Base64 stream encoder.
// No dependencies; used by the front end, queue, back end, top level and checker.
package b64e_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // One queued command: the characters that one input byte causes.
    typedef struct packed {
        logic [3:0][5:0] sextet;   // sextet[0] is emitted first
        logic [1:0]      nchar_m1; // number of characters minus one
        logic [1:0]      npad;     // trailing '=' characters among them
        logic            last;     // the command ends the message
    } entry_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
        logic [7:0] code;
        code = 8'h2F;
        if (v < 6'd26) begin
            code = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            code = 8'h61 + ({2'b00, v} - 8'd26);
        end else if (v < 6'd62) begin
            code = 8'h30 + ({2'b00, v} - 8'd52);
        end else if (v == 6'd62) begin
            code = 8'h2B;
        end
        return code;
    endfunction

endpackage

FILE: sv/b64e_stream_if.sv
// Handshake channels of the Base64 stream encoder: message bytes in, characters out.
// No dependencies.
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

FILE: sv/b64e_front.sv
// Front end: accepts message bytes, tracks the group phase and carry bits,
// and turns each byte into one queue command. Depends on b64e_pkg, b64e_byte_if.
module b64e_front
(
    input  logic                clk,
    input  logic                rst_n,
    b64e_byte_if.sink           msg,
    input  logic                full,
    output logic                push,
    output b64e_pkg::entry_t    entry,
    output logic [1:0]          phase
);

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] carry_reg;
    logic [3:0] carry_next;
    logic [7:0] b;
    logic       fin;

    assign msg.ready = !full;
    assign push      = msg.valid && !full;
    assign phase     = phase_reg;
    assign b         = msg.data_byte;
    assign fin       = msg.last_byte;

    always_comb
    begin
        entry          = '0;
        entry.last     = fin;
        phase_next     = PH_FIRST;
        carry_next     = 4'd0;
        case (phase_reg)
            PH_SECOND:
            begin
                entry.sextet[0] = {carry_reg[1:0], b[7:4]};
                if (fin)
                begin
                    entry.sextet[1] = {b[3:0], 2'b00};
                    entry.nchar_m1  = 2'd2;
                    entry.npad      = 2'd1;
                end
                else
                begin
                    phase_next = PH_THIRD;
                    carry_next = b[3:0];
                end
            end
            PH_THIRD:
            begin
                entry.sextet[0] = {carry_reg, b[7:6]};
                entry.sextet[1] = b[5:0];
                entry.nchar_m1  = 2'd1;
            end
            default:
            begin
                // The unused fourth phase code behaves as the start of a group.
                entry.sextet[0] = b[7:2];
                if (fin)
                begin
                    entry.sextet[1] = {b[1:0], 4'b0000};
                    entry.nchar_m1  = 2'd3;
                    entry.npad      = 2'd2;
                end
                else
                begin
                    phase_next = PH_SECOND;
                    carry_next = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            carry_reg <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

FILE: sv/b64e_queue.sv
// Command queue between the front end and the character emitter.
// Circular buffer in flip-flops. Depends on b64e_pkg.
module b64e_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  b64e_pkg::entry_t              entry_in,
    output logic                          full,
    output logic                          head_valid,
    output b64e_pkg::entry_t              head,
    input  logic                          pop,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::entry_t   mem [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

FILE: sv/b64e_back.sv
// Back end: walks the queue head into an output register, one character per cycle
// while enc is not stalled. Depends on b64e_pkg and b64e_char_if.
module b64e_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  b64e_pkg::entry_t    head,
    output logic                pop,
    b64e_char_if.source         enc,
    output logic [1:0]          char_idx
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       oval_reg;
    logic       oval_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       load;
    logic       is_end;
    logic       is_pad;
    logic [7:0] char_code;

    assign load   = head_valid && (!oval_reg || enc.ready);
    assign is_end = (idx_reg == head.nchar_m1);
    // Pads fill the tail of the command's characters.
    assign is_pad = ({1'b0, idx_reg} + {1'b0, head.npad}) > {1'b0, head.nchar_m1};
    assign pop    = load && is_end;

    assign char_code = is_pad ? b64e_pkg::PAD_CHAR
                              : b64e_pkg::sextet_to_ascii(head.sextet[idx_reg]);

    assign idx_next  = is_end ? 2'd0 : idx_reg + 2'd1;
    assign oval_next = load ? 1'b1 : (enc.ready ? 1'b0 : oval_reg);

    assign enc.valid     = oval_reg;
    assign enc.out_char  = char_reg;
    assign enc.last_char = last_reg;
    assign char_idx      = idx_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_code;
            last_reg <= head.last && is_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            oval_reg <= 1'b0;
        end
        else
        begin
            oval_reg <= oval_next;
            if (load)
            begin
                idx_reg <= idx_next;
            end
        end
    end

endmodule

FILE: sv/base64_stream_encoder_unit.sv
// Top level of the Base64 stream encoder: front end, command queue, character emitter.
// Depends on b64e_pkg, b64e_stream_if, b64e_front, b64e_queue, b64e_back, assert_macros.svh.
//
//   channel | dir | payload                  | beat
//   --------+-----+--------------------------+-----------------------------------
//   msg     | in  | data_byte[7:0] last_byte | one message byte
//   enc     | out | out_char[7:0] last_char  | one Base64 character or '=' pad
//
// A byte is taken whenever the queue has room; it yields one to four characters,
// and the emitter sends them from its output register, one character per cycle
// while enc is ready, also in long messages. The first character of a byte passes
// through the queue and then the output register before it is valid.
// Reset clears the group phase, carry bits, queue pointers and count, and output valid flag.
// A stall on enc holds the output register; once the queue fills, msg.ready drops.
`include "assert_macros.svh"

module base64_stream_encoder_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    b64e_byte_if.sink   msg,
    b64e_char_if.source enc
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic               push;
    logic               full;
    logic               head_valid;
    logic               pop;
    logic [1:0]         phase;
    logic [1:0]         char_idx;
    logic [CNT_W-1:0]   q_count;
    b64e_pkg::entry_t   entry;
    b64e_pkg::entry_t   head;

    b64e_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .full  (full),
        .push  (push),
        .entry (entry),
        .phase (phase)
    );

    b64e_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .entry_in   (entry),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .count      (q_count)
    );

    b64e_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .enc        (enc),
        .char_idx   (char_idx)
    );

    // A final byte always returns the encoder to the start of a group.
    `B64E_ASSERT_NXT(a_final_resets_phase, msg.valid && msg.ready && msg.last_byte, phase == 2'd0)
    // A byte is only taken while the queue has a free slot.
    `B64E_ASSERT_IMP(a_no_overflow, msg.valid && msg.ready, q_count < CNT_W'(QUEUE_DEPTH))
    // With nothing queued and nothing held, no character can appear next cycle.
    `B64E_ASSERT_NXT(a_no_phantom_char, (q_count == '0) && !enc.valid, !enc.valid)
    // The message's final character leaves only after its command is fully walked.
    `B64E_ASSERT_IMP(a_last_char_idx, enc.valid && enc.ready && enc.last_char, char_idx == 2'd0)

endmodule

FILE: tb/b64e_checker.sv
// Scoreboard for the Base64 stream encoder: predicts the characters of each accepted byte.
// Depends on b64e_pkg (pad code) and the b64e_byte_if / b64e_char_if interfaces.
// Watches both channels passively and counts mismatches for the testbench top.
module b64e_checker
(
    input  logic        clk,
    input  logic        rst_n,
    b64e_byte_if        msg,
    b64e_char_if        enc,
    output int unsigned fail_count,
    output int unsigned chars_checked,
    output int unsigned pending_chars
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        GRP_FIRST,
        GRP_SECOND,
        GRP_THIRD
    } grp_pos_e;

    typedef struct packed {
        logic [7:0] code;
        logic       fin;
    } enc_char_t;

    // Entry 0 sits in the top byte, so the index is the sextet value.
    localparam logic [0:63][7:0] B64_DIGITS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    grp_pos_e   grp_pos;
    logic [3:0] carry_nib;
    enc_char_t  expected_chars[$];

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] MISMATCH on character %0d: %s", $realtime, chars_checked, what);
    endtask

    task automatic expect_char(input logic [7:0] code, input logic fin);
        enc_char_t item;
        item.code = code;
        item.fin  = fin;
        expected_chars.push_back(item);
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        case (grp_pos)
            GRP_SECOND:
            begin
                expect_char(B64_DIGITS[{carry_nib[1:0], b[7:4]}], 1'b0);
                if (fin)
                begin
                    expect_char(B64_DIGITS[{b[3:0], 2'b00}], 1'b0);
                    expect_char(b64e_pkg::PAD_CHAR, 1'b1);
                    grp_pos   = GRP_FIRST;
                    carry_nib = 4'd0;
                end
                else
                begin
                    grp_pos   = GRP_THIRD;
                    carry_nib = b[3:0];
                end
            end
            GRP_THIRD:
            begin
                expect_char(B64_DIGITS[{carry_nib, b[7:6]}], 1'b0);
                expect_char(B64_DIGITS[b[5:0]], fin);
                grp_pos   = GRP_FIRST;
                carry_nib = 4'd0;
            end
            default:
            begin
                expect_char(B64_DIGITS[b[7:2]], 1'b0);
                if (fin)
                begin
                    // A lone byte closes with a zero-filled character and two pads.
                    expect_char(B64_DIGITS[{b[1:0], 4'b0000}], 1'b0);
                    expect_char(b64e_pkg::PAD_CHAR, 1'b0);
                    expect_char(b64e_pkg::PAD_CHAR, 1'b1);
                    grp_pos   = GRP_FIRST;
                    carry_nib = 4'd0;
                end
                else
                begin
                    grp_pos   = GRP_SECOND;
                    carry_nib = {2'b00, b[1:0]};
                end
            end
        endcase
    endtask

    task automatic check_char(input logic [7:0] code, input logic fin);
        enc_char_t want;
        if (expected_chars.size() == 0)
        begin
            report_mismatch($sformatf("unexpected character 0x%02h last=%0b", code, fin));
        end
        else
        begin
            want = expected_chars.pop_front();
            if (code !== want.code)
            begin
                report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                          code, want.code));
            end
            if (fin !== want.fin)
            begin
                report_mismatch($sformatf("last_char %0b, expected %0b", fin, want.fin));
            end
        end
        chars_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_chars.delete();
            grp_pos       = GRP_FIRST;
            carry_nib     = 4'd0;
            pending_chars = 0;
        end
        else
        begin
            if (msg.valid && msg.ready)
            begin
                encode_byte(msg.data_byte, msg.last_byte);
            end
            if (enc.valid && enc.ready)
            begin
                check_char(enc.out_char, enc.last_char);
            end
            pending_chars = expected_chars.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for base64_stream_encoder_unit: clock, reset, byte stimulus, sink stalls.
// Depends on the RTL, the channel interfaces and b64e_checker, which does the scoring.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BYTES = 235;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef enum int unsigned {
        RX_STREAM,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_e;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned chars_checked;
    int unsigned pending_chars;
    int unsigned hold_requests = 0;
    int unsigned bytes_sent    = 0;
    int unsigned msgs_sent     = 0;
    int unsigned burst_left    = 0;
    int unsigned cycle_count   = 0;
    logic [7:0]  message[$];

    b64e_byte_if msg_if ();
    b64e_char_if enc_if ();

    base64_stream_encoder_unit u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .enc   (enc_if)
    );

    b64e_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .msg           (msg_if),
        .enc           (enc_if),
        .fail_count    (fail_count),
        .chars_checked (chars_checked),
        .pending_chars (pending_chars)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d characters outstanding",
                 cycle_count, pending_chars);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        msg_if.valid     <= 1'b1;
        msg_if.data_byte <= b;
        msg_if.last_byte <= fin;
        @(negedge clk);
        while (!msg_if.ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_message(input bit steady);
        int unsigned gap;
        for (int i = 0; i < message.size(); i++)
        begin
            send_byte(message[i], i == message.size() - 1);
            if (!steady)
            begin
                if (burst_left != 0)
                begin
                    burst_left--;
                end
                if (burst_left == 0)
                begin
                    gap = $urandom_range(0, 5);
                    if (gap != 0)
                    begin
                        // Idle data is noise that the block must ignore.
                        msg_if.valid     <= 1'b0;
                        msg_if.data_byte <= 8'($urandom);
                        msg_if.last_byte <= 1'($urandom);
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(1, 8);
                end
            end
        end
        msgs_sent++;
    endtask

    initial
    begin : char_sink
        rx_mode_e    mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned holds_served;
        int unsigned tick;
        enc_if.ready <= 1'b0;
        mode         = RX_STREAM;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        tick         = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left != 0)
            begin
                hold_left--;
                enc_if.ready <= 1'b0;
            end
            else if (holds_served != hold_requests)
            begin
                // Long back-pressure so the queue fills and msg.ready drops.
                holds_served++;
                hold_left    = HOLD_CYCLES - 1;
                enc_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_STREAM:   enc_if.ready <= 1'b1;
                    RX_LIGHT:    enc_if.ready <= ($urandom_range(0, 4) != 0);
                    RX_HEAVY:    enc_if.ready <= ($urandom_range(0, 2) == 0);
                    default:     enc_if.ready <= ((tick % 5) < 3);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int unsigned n_len;
        int unsigned directed_bytes;
        bit          pressure_done;
        msg_if.valid     <= 1'b0;
        msg_if.data_byte <= 8'h00;
        msg_if.last_byte <= 1'b0;
        rst_n            <= 1'b0;
        pressure_done    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-byte messages: two pads.
        message = '{8'h00};
        send_message(1'b0);
        message = '{8'hFF};
        send_message(1'b0);
        // Two-byte messages: one pad.
        message = '{8'hFF, 8'hFF};
        send_message(1'b0);
        message = '{8'h00, 8'h00};
        send_message(1'b0);
        // Full groups: no pad, including '+' and '/'.
        message = '{8'h4D, 8'h61, 8'h6E};
        send_message(1'b0);
        message = '{8'hFB, 8'hEF, 8'hBE};
        send_message(1'b0);
        message = '{8'hFF, 8'hFF, 8'hFF};
        send_message(1'b0);
        message = '{8'h00, 8'h00, 8'h00};
        send_message(1'b0);
        // Message that runs past one group.
        message = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10};
        send_message(1'b0);
        directed_bytes = bytes_sent;

        while (bytes_sent < directed_bytes + RANDOM_BYTES)
        begin
            n_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            if (!pressure_done && bytes_sent > directed_bytes + 100)
            begin
                n_len = 30;
            end
            message.delete();
            repeat (n_len)
            begin
                case ($urandom_range(0, 7))
                    0:       message.push_back(8'h00);
                    1:       message.push_back(8'hFF);
                    default: message.push_back(8'($urandom));
                endcase
            end
            if (!pressure_done && bytes_sent > directed_bytes + 100)
            begin
                pressure_done = 1'b1;
                hold_requests <= hold_requests + 1;
                send_message(1'b1);
            end
            else
            begin
                send_message(1'b0);
            end
        end
        msg_if.valid <= 1'b0;

        @(negedge clk);
        while (pending_chars != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Encoded %0d bytes in %0d messages (%0d directed bytes), %0d characters",
                 bytes_sent, msgs_sent, directed_bytes, chars_checked);
        $display("checked under random bursts, sink stalls and one %0d-cycle sink hold.",
                 HOLD_CYCLES);
        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/b64e_pkg.sv
sv/b64e_stream_if.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder_unit.sv
tb/b64e_checker.sv
tb/tb_top.sv
